FILE: hw/rtl/rrdq_pkg.sv
// Shared types and constants of the round-robin scheduler with a mean-based quantum.
// No dependencies; used by the core, the front end and the back end, and by the testbench.
`timescale 1ns / 1ps

package rrdq_pkg;

	localparam int SLOT_W          = 6;
	localparam int TIME_W          = 16;
	localparam int DEF_TABLE_DEPTH = 64;
	localparam int QUEUE_DEPTH     = 2;

	// Input item.
	typedef struct packed {
		logic              func;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] exec_time;
	} req_t;

	// Result item.
	typedef struct packed {
		logic [SLOT_W-1:0] task_slot;
		logic [TIME_W-1:0] granted_time;
		logic [TIME_W-1:0] remaining_after;
		logic              finished;
		logic [TIME_W-1:0] round_quantum;
		logic              last_of_round;
	} rsp_t;

	// Function codes of the input item.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_ROUND = 1'b1;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_ROUND = 1'b1
	} op_t;

	// Classified command passed from the front end to the back end.
	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] exec_time;
	} cmd_t;

	typedef logic [SLOT_W:0] slot_ext_t;

endpackage

FILE: hw/rtl/round_robin_dynamic_quantum_core.sv
// Round-robin scheduler whose quantum is the mean of the active remaining times.
// A load item is written to the table while the back end is idle. A round holds the back
// end for two table sweeps at one entry a cycle, each with read latency and drain, and a
// one-bit-per-cycle divider, plus any output stalls. Rounds therefore run one after another.
// The first result of a round comes from the second sweep, once the division is done.
// Reset (arst_n, asynchronous) marks every slot inactive at once and empties the queue.
`timescale 1ns / 1ps

module round_robin_dynamic_quantum_core #(
	parameter int TABLE_DEPTH = rrdq_pkg::DEF_TABLE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rrdq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rrdq_pkg::rsp_t rsp
);

	logic           cmd_valid;
	logic           cmd_ready;
	rrdq_pkg::cmd_t cmd;

	rrdq_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	rrdq_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

FILE: hw/rtl/rrdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rrdq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/rrdq_front.sv
// Front end: accepts input items, classifies them and queues commands for the back end.
// Depends on rrdq_pkg.
`timescale 1ns / 1ps

module rrdq_front #(
	parameter int TABLE_DEPTH = rrdq_pkg::DEF_TABLE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rrdq_pkg::req_t req,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output rrdq_pkg::cmd_t cmd
);

	localparam int QPTR_W = (rrdq_pkg::QUEUE_DEPTH > 1) ? $clog2(rrdq_pkg::QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(rrdq_pkg::QUEUE_DEPTH + 1);

	rrdq_pkg::cmd_t    queue_q [rrdq_pkg::QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	rrdq_pkg::cmd_t    cmd_new;
	logic              keep;
	logic              push;
	logic              pop;

	// A load aimed beyond the table is dropped here and never reaches the back end.
	always_comb begin
		cmd_new.slot      = req.slot;
		cmd_new.exec_time = req.exec_time;
		if (req.func == rrdq_pkg::FUNC_ROUND) begin
			cmd_new.op = rrdq_pkg::OP_ROUND;
			keep       = 1'b1;
		end else begin
			cmd_new.op = rrdq_pkg::OP_LOAD;
			keep       = ({1'b0, req.slot} < rrdq_pkg::slot_ext_t'(TABLE_DEPTH));
		end
	end

	assign req_ready = (count_q != QCNT_W'(rrdq_pkg::QUEUE_DEPTH));
	assign push      = req_valid && req_ready && keep;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(rrdq_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(rrdq_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/rrdq_back.sv
// Back end: executes loads and scheduling rounds against the remaining-time table.
// Depends on rrdq_pkg and rrdq_ram.
`timescale 1ns / 1ps

module rrdq_back #(
	parameter int TABLE_DEPTH = rrdq_pkg::DEF_TABLE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  rrdq_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rrdq_pkg::rsp_t rsp
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int TW     = rrdq_pkg::TIME_W;
	localparam int SUM_W  = TW + CNT_W;
	localparam int DCNT_W = $clog2(SUM_W + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SUM   = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_GRANT = 4'b1000
	} state_t;

	state_t             state_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]   rd_ptr_q;
	logic               ev_vld_q;
	logic [IDX_W-1:0]   ev_idx_q;
	logic               ev_written_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   last_q;
	logic [CNT_W-1:0]   div_rem_q;
	logic [SUM_W-1:0]   div_quo_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [TW-1:0]      quantum_q;
	logic               rsp_valid_q;
	rrdq_pkg::rsp_t     rsp_q;

	logic [TW-1:0]      rdata;
	logic [TW-1:0]      ev_rem;
	logic               ev_act;
	logic               walking;
	logic               out_free;
	logic               stall;
	logic               advance;
	logic               ptr_more;
	logic               pass_done;
	logic               take_load;
	logic               grant_fire;
	logic [TW-1:0]      grant;
	logic [TW-1:0]      rem_after;
	logic [CNT_W:0]     div_trial;
	logic               div_bit;
	logic [CNT_W-1:0]   div_rem_next;
	logic [SUM_W-1:0]   div_quo_next;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [TW-1:0]      ram_wdata;
	logic               ram_re;

	rrdq_ram #(
		.WIDTH(TW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_ptr_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	// An entry never written since reset reads as zero, i.e. inactive.
	assign ev_rem    = ev_written_q ? rdata : '0;
	assign ev_act    = ev_vld_q && (ev_rem != '0);
	assign grant     = (ev_rem <= quantum_q) ? ev_rem : quantum_q;
	assign rem_after = ev_rem - grant;

	assign walking   = (state_q == ST_SUM) || (state_q == ST_GRANT);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign stall     = (state_q == ST_GRANT) && ev_act && !out_free;
	assign advance   = walking && !stall;
	assign ptr_more  = (rd_ptr_q < CNT_W'(TABLE_DEPTH));
	assign pass_done = walking && !ptr_more && !ev_vld_q;
	assign ram_re    = advance && ptr_more;
	assign grant_fire = (state_q == ST_GRANT) && ev_act && out_free;

	assign cmd_ready = (state_q == ST_IDLE);
	assign take_load = cmd_valid && cmd_ready && (cmd.op == rrdq_pkg::OP_LOAD);

	always_comb begin
		if (take_load) begin
			ram_we    = 1'b1;
			ram_waddr = cmd.slot[IDX_W-1:0];
			ram_wdata = cmd.exec_time;
		end else begin
			ram_we    = grant_fire;
			ram_waddr = ev_idx_q;
			ram_wdata = rem_after;
		end
	end

	// One bit of the restoring division of the sum by the active count.
	always_comb begin
		div_trial = {div_rem_q, div_quo_q[SUM_W-1]};
		div_bit   = (div_trial >= {1'b0, cnt_q});
		if (div_bit) begin
			div_rem_next = CNT_W'(div_trial - {1'b0, cnt_q});
		end else begin
			div_rem_next = div_trial[CNT_W-1:0];
		end
		div_quo_next = {div_quo_q[SUM_W-2:0], div_bit};
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			ev_idx_q     <= rd_ptr_q[IDX_W-1:0];
			ev_written_q <= valid_q[rd_ptr_q[IDX_W-1:0]];
		end
		if (grant_fire) begin
			rsp_q.task_slot       <= rrdq_pkg::SLOT_W'(ev_idx_q);
			rsp_q.granted_time    <= grant;
			rsp_q.remaining_after <= rem_after;
			rsp_q.finished        <= (rem_after == '0);
			rsp_q.round_quantum   <= quantum_q;
			rsp_q.last_of_round   <= (ev_idx_q == last_q);
		end
		if (state_q == ST_IDLE) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			last_q <= '0;
		end else if ((state_q == ST_SUM) && ev_act) begin
			sum_q  <= sum_q + SUM_W'(ev_rem);
			cnt_q  <= cnt_q + CNT_W'(1);
			last_q <= ev_idx_q;
		end
		if ((state_q == ST_SUM) && pass_done) begin
			div_rem_q <= '0;
			div_quo_q <= sum_q;
			div_cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_rem_q <= div_rem_next;
			div_quo_q <= div_quo_next;
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
			if (div_cnt_q == DCNT_W'(SUM_W - 1)) begin
				quantum_q <= div_quo_next[TW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			rd_ptr_q    <= '0;
			ev_vld_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take_load) begin
				valid_q[cmd.slot[IDX_W-1:0]] <= 1'b1;
			end
			if (grant_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (advance) begin
				if (ptr_more) begin
					rd_ptr_q <= rd_ptr_q + CNT_W'(1);
					ev_vld_q <= 1'b1;
				end else begin
					ev_vld_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_ptr_q <= '0;
					ev_vld_q <= 1'b0;
					if (cmd_valid && (cmd.op == rrdq_pkg::OP_ROUND)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (pass_done) begin
						// A round with no active slot ends here with no result.
						state_q <= (cnt_q == '0) ? ST_IDLE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == DCNT_W'(SUM_W - 1)) begin
						state_q  <= ST_GRANT;
						rd_ptr_q <= '0;
						ev_vld_q <= 1'b0;
					end
				end
				ST_GRANT: begin
					if (pass_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: sim/rrdq_checker.sv
// Checker for the round-robin scheduler core: watches both channels and predicts each round.
// Depends on rrdq_pkg for the item types; the top level reads its failure and pending counts.
`timescale 1ns / 1ps

module rrdq_checker #(
	parameter int TABLE_DEPTH = rrdq_pkg::DEF_TABLE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  rrdq_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  rrdq_pkg::rsp_t rsp,
	output int             fail_count,
	output int             pending
);
	import rrdq_pkg::*;

	logic [TIME_W-1:0] remain_tbl [TABLE_DEPTH];
	rsp_t              grant_q [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic report(input string msg);
		$display("rrdq_checker: %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [TIME_W-1:0] got,
			input logic [TIME_W-1:0] want, input logic [SLOT_W-1:0] slot_no);
		if (got !== want) begin
			report($sformatf("slot %0d: %s is %0d, expected %0d", slot_no, name, got, want));
		end
	endtask

	// Works out the grants of one round and updates the table as the block should.
	task automatic predict_round();
		logic [31:0]       total;
		int                count;
		int                last;
		logic [TIME_W-1:0] quantum;
		logic [TIME_W-1:0] grant;
		rsp_t              grant_item;
		total = '0;
		count = 0;
		last  = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (remain_tbl[i] != '0) begin
				total += 32'(remain_tbl[i]);
				count++;
				last = i;
			end
		end
		if (count == 0) return;
		quantum = TIME_W'(total / count);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (remain_tbl[i] != '0) begin
				grant = (remain_tbl[i] <= quantum) ? remain_tbl[i] : quantum;
				remain_tbl[i] = remain_tbl[i] - grant;
				grant_item.task_slot       = SLOT_W'(i);
				grant_item.granted_time    = grant;
				grant_item.remaining_after = remain_tbl[i];
				grant_item.finished        = (remain_tbl[i] == '0);
				grant_item.round_quantum   = quantum;
				grant_item.last_of_round   = (i == last);
				grant_q.push_back(grant_item);
			end
		end
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (grant_q.size() == 0) begin
			report($sformatf("item for slot %0d arrived with none expected", got.task_slot));
			return;
		end
		want = grant_q.pop_front();
		compare_field("task_slot", TIME_W'(got.task_slot), TIME_W'(want.task_slot),
			want.task_slot);
		compare_field("granted_time", got.granted_time, want.granted_time, want.task_slot);
		compare_field("remaining_after", got.remaining_after, want.remaining_after,
			want.task_slot);
		compare_field("finished", TIME_W'(got.finished), TIME_W'(want.finished),
			want.task_slot);
		compare_field("round_quantum", got.round_quantum, want.round_quantum, want.task_slot);
		compare_field("last_of_round", TIME_W'(got.last_of_round), TIME_W'(want.last_of_round),
			want.task_slot);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) remain_tbl[i] = '0;
			grant_q.delete();
		end else begin
			if (rsp_valid && rsp_ready) check_result(rsp);
			if (req_valid && req_ready) begin
				if (req.func == FUNC_ROUND) begin
					predict_round();
				end else if (req.slot < TABLE_DEPTH) begin
					remain_tbl[req.slot] = req.exec_time;
				end
			end
		end
		pending = grant_q.size();
	end

endmodule

FILE: sim/tb.sv
// Top level of the scheduler core testbench: clock, reset, item stimulus and the verdict.
// Depends on rrdq_pkg, round_robin_dynamic_quantum_core and rrdq_checker.
`timescale 1ns / 1ps

module tb;
	import rrdq_pkg::*;

	localparam int DEPTH     = DEF_TABLE_DEPTH;
	localparam int N_RANDOM  = 110;
	localparam int HOLD_OFF  = 600;
	localparam int TAIL_WAIT = 400;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	int   fail_count;
	int   pending;

	bit send_burst;
	int send_run;

	round_robin_dynamic_quantum_core #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	rrdq_checker #(
		.TABLE_DEPTH(DEPTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Random gaps come in runs, some of which have no gaps at all.
	task automatic send_item(input logic f, input logic [SLOT_W-1:0] s,
			input logic [TIME_W-1:0] e);
		int gap;
		if (send_run == 0) begin
			send_burst = ($urandom_range(0, 3) == 0);
			send_run   = $urandom_range(4, 20);
		end
		send_run--;
		gap = send_burst ? 0 : $urandom_range(0, 18);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= {f, s, e};
		do @(posedge clk); while (!req_ready);
	endtask

	function automatic logic [TIME_W-1:0] load_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 15) return '1;
		if (r < 35) return TIME_W'($urandom);
		return TIME_W'($urandom_range(1, 40));
	endfunction

	initial begin : receiver
		int  gap;
		int  taken;
		int  run;
		bit  burst;
		bit  held;
		taken = 0;
		run   = 0;
		burst = 1'b0;
		held  = 1'b0;
		@(posedge arst_n);
		forever begin
			// Early on, stop taking results for a long time so the core backs up.
			if (!held && taken == 3) begin
				held = 1'b1;
				repeat (HOLD_OFF) begin
					@(negedge clk);
					rsp_ready <= 1'b0;
				end
			end
			if (run == 0) begin
				burst = ($urandom_range(0, 3) == 0);
				run   = $urandom_range(4, 20);
			end
			run--;
			gap = burst ? 0 : $urandom_range(0, 18);
			repeat (gap) begin
				@(negedge clk);
				rsp_ready <= 1'b0;
			end
			@(negedge clk);
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			taken++;
		end
	end

	initial begin
		#9_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int pick;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		rsp_ready  = 1'b0;
		send_burst = 1'b0;
		send_run   = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty table first, then the field extremes and a lone task.
		send_item(FUNC_ROUND, '0, '0);
		send_item(FUNC_LOAD, 6'd0, 16'hFFFF);
		send_item(FUNC_LOAD, 6'd63, 16'd1);
		send_item(FUNC_ROUND, 6'd63, 16'hFFFF);
		send_item(FUNC_ROUND, 6'd17, 16'h1234);
		send_item(FUNC_ROUND, '0, '0);
		send_item(FUNC_LOAD, 6'd5, 16'd7);
		send_item(FUNC_ROUND, '0, '0);
		send_item(FUNC_LOAD, 6'd31, 16'hAAAA);
		send_item(FUNC_LOAD, 6'd32, 16'h5555);
		send_item(FUNC_LOAD, 6'd63, 16'hFFFF);
		send_item(FUNC_ROUND, '0, '0);
		send_item(FUNC_LOAD, 6'd32, 16'd0);
		send_item(FUNC_ROUND, '0, '0);
		send_item(FUNC_LOAD, 6'd0, 16'd3);
		send_item(FUNC_LOAD, 6'd1, 16'd3);
		send_item(FUNC_ROUND, '1, '1);
		send_item(FUNC_LOAD, 6'd31, 16'd0);
		send_item(FUNC_LOAD, 6'd63, 16'd0);
		send_item(FUNC_ROUND, '0, '0);

		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_item(FUNC_ROUND, SLOT_W'($urandom), TIME_W'($urandom));
			end else begin
				send_item(FUNC_LOAD, SLOT_W'($urandom_range(0, DEPTH - 1)), load_time());
			end
		end
		@(negedge clk);
		req_valid <= 1'b0;

		wait (pending == 0);
		repeat (TAIL_WAIT) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/rrdq_pkg.sv
hw/rtl/rrdq_ram.sv
hw/rtl/rrdq_front.sv
hw/rtl/rrdq_back.sv
hw/rtl/round_robin_dynamic_quantum_core.sv
sim/rrdq_checker.sv
sim/tb.sv
